// File: rtl/pddc_pkg.sv
// Shared constants, codes and word types for the paged disk DMA controller.
package pddc_pkg;

  localparam int PageShiftDef = 12;
  localparam int PageShiftMax = 16;

  // Bus-wide command byte that mutes the interrupt.
  localparam logic [7:0] MuteCode = 8'h01;

  // Register select codes for bus writes.
  localparam logic [2:0] SEL_CMD     = 3'd0;
  localparam logic [2:0] SEL_PAGE_LO = 3'd1;
  localparam logic [2:0] SEL_PAGE_HI = 3'd2;
  localparam logic [2:0] SEL_SLOT    = 3'd3;
  localparam logic [2:0] SEL_BUS     = 3'd4;

  // Disk commands.
  localparam logic [7:0] CMD_NONE    = 8'h00;
  localparam logic [7:0] CMD_GETSIZE = 8'h20;
  localparam logic [7:0] CMD_SYNC    = 8'h30;
  localparam int         CmdWriteBit = 4;

  // Status bits and error codes.
  localparam logic [7:0] STAT_DONE      = 8'h80;
  localparam logic [7:0] STAT_ERR_SLOT  = 8'he1;
  localparam logic [7:0] STAT_ERR_SEEK  = 8'he2;
  localparam logic [7:0] STAT_ERR_WRITE = 8'he3;
  localparam logic [7:0] STAT_ERR_READ  = 8'he4;

  // Values loaded by GETSIZE.
  localparam logic [7:0] MAX_PAGE_BYTE = 8'hff;
  localparam logic [7:0] MAX_SLOT      = 8'h0f;

  typedef struct packed {
    logic       command;
    logic [2:0] reg_select;
    logic [7:0] bus_data;
    logic       seek_ok;
    logic       io_ok;
    logic       read_eof;
    logic [7:0] disk_byte;
    logic [7:0] mem_byte;
  } req_word_t;

  typedef struct packed {
    logic [7:0]  status;
    logic [23:0] param_word;
    logic        irq_raise;
    logic        busy_res;
    logic        seek_valid;
    logic [27:0] seek_address;
    logic        xfer_valid;
    logic        xfer_write;
    logic [3:0]  mem_slot;
    logic [11:0] mem_offset;
    logic [7:0]  mem_write_data;
    logic [7:0]  disk_write_data;
  } rsp_word_t;

endpackage

// File: rtl/pddc_req_if.sv
// Request channel: bus writes and transfer ticks into the controller.
interface pddc_req_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [2:0] reg_select;
  logic [7:0] bus_data;
  logic       seek_ok;
  logic       io_ok;
  logic       read_eof;
  logic [7:0] disk_byte;
  logic [7:0] mem_byte;

  modport source (
    output valid, command, reg_select, bus_data, seek_ok, io_ok, read_eof,
           disk_byte, mem_byte,
    input  ready
  );
  modport sink (
    input  valid, command, reg_select, bus_data, seek_ok, io_ok, read_eof,
           disk_byte, mem_byte,
    output ready
  );
endinterface

// File: rtl/pddc_rsp_if.sv
// Response channel: status, registers and the access made by each word.
interface pddc_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  status;
  logic [23:0] param_word;
  logic        irq_raise;
  logic        busy_res;
  logic        seek_valid;
  logic [27:0] seek_address;
  logic        xfer_valid;
  logic        xfer_write;
  logic [3:0]  mem_slot;
  logic [11:0] mem_offset;
  logic [7:0]  mem_write_data;
  logic [7:0]  disk_write_data;

  modport source (
    output valid, status, param_word, irq_raise, busy_res, seek_valid, seek_address,
           xfer_valid, xfer_write, mem_slot, mem_offset, mem_write_data,
           disk_write_data,
    input  ready
  );
  modport sink (
    input  valid, status, param_word, irq_raise, busy_res, seek_valid, seek_address,
           xfer_valid, xfer_write, mem_slot, mem_offset, mem_write_data,
           disk_write_data,
    output ready
  );
endinterface

// File: rtl/paged_disk_dma_controller.sv
// Paged disk DMA controller: input register, single-pass execute, output register.
// A word accepted into the input register executes once the output register is free or
// draining, and its response is registered in the output register.
// Throughput: one word per cycle unless the response side stalls; the controller
// registers update as the word leaves the input register, so the next word sees
// them immediately. Reset (synchronous, rst high) clears all controller registers
// and the valid flags of both register stages; no clearing pass is needed.
module paged_disk_dma_controller #(
  parameter int PAGE_SHIFT = pddc_pkg::PageShiftDef
) (
  input logic         clk,
  input logic         rst,
  pddc_req_if.sink    req,
  pddc_rsp_if.source  rsp
);
  import pddc_pkg::*;

  logic      in_valid;
  req_word_t in_word;
  logic      out_valid;
  rsp_word_t out_word;
  rsp_word_t exec_word;
  logic      fire;

  // The execute step moves a word whenever the output register is free or draining.
  assign fire      = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_word.command    <= req.command;
      in_word.reg_select <= req.reg_select;
      in_word.bus_data   <= req.bus_data;
      in_word.seek_ok    <= req.seek_ok;
      in_word.io_ok      <= req.io_ok;
      in_word.read_eof   <= req.read_eof;
      in_word.disk_byte  <= req.disk_byte;
      in_word.mem_byte   <= req.mem_byte;
    end
  end

  pddc_exec #(
    .PAGE_SHIFT(PAGE_SHIFT)
  ) u_exec (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .req_word (in_word),
    .rsp_word (exec_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word <= exec_word;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_word.status;
  assign rsp.param_word      = out_word.param_word;
  assign rsp.irq_raise       = out_word.irq_raise;
  assign rsp.busy_res        = out_word.busy_res;
  assign rsp.seek_valid      = out_word.seek_valid;
  assign rsp.seek_address    = out_word.seek_address;
  assign rsp.xfer_valid      = out_word.xfer_valid;
  assign rsp.xfer_write      = out_word.xfer_write;
  assign rsp.mem_slot        = out_word.mem_slot;
  assign rsp.mem_offset      = out_word.mem_offset;
  assign rsp.mem_write_data  = out_word.mem_write_data;
  assign rsp.disk_write_data = out_word.disk_write_data;

endmodule

// File: rtl/pddc_exec.sv
// Controller registers and the single-pass logic that runs one word against them.
module pddc_exec #(
  parameter int PAGE_SHIFT = pddc_pkg::PageShiftDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  pddc_pkg::req_word_t req_word,
  output pddc_pkg::rsp_word_t rsp_word
);
  import pddc_pkg::*;

  localparam int LimW = 4 + PAGE_SHIFT;
  localparam int CmpW = (LimW > 16) ? LimW : 16;

  logic [7:0]  cmd_status, cmd_status_next;
  logic [7:0]  page_low, page_low_next;
  logic [7:0]  page_high, page_high_next;
  logic [7:0]  slot_reg, slot_reg_next;
  logic [15:0] byte_count, byte_count_next;
  logic        active, active_next;
  logic        seeked, seeked_next;
  logic        sync_pending, sync_pending_next;
  logic        muted, muted_next;

  logic        failed;
  logic        finish;
  logic        wr;
  logic [15:0] count_inc;
  logic [11:0] off_mask;
  logic [LimW-1:0] limit;
  logic [27:0] seek_addr_calc;

  assign count_inc      = byte_count + 16'd1;
  assign off_mask       = 12'((32'd1 << PAGE_SHIFT) - 32'd1);
  assign limit          = LimW'(cmd_status[3:0]) << PAGE_SHIFT;
  assign seek_addr_calc = 28'({page_high, page_low}) << PAGE_SHIFT;
  assign wr             = cmd_status[CmdWriteBit];

  always_comb begin
    cmd_status_next   = cmd_status;
    page_low_next     = page_low;
    page_high_next    = page_high;
    slot_reg_next     = slot_reg;
    byte_count_next   = byte_count;
    active_next       = active;
    seeked_next       = seeked;
    sync_pending_next = sync_pending;
    muted_next        = muted;
    failed            = 1'b0;
    finish            = 1'b0;
    rsp_word          = '0;

    if (!req_word.command) begin
      case (req_word.reg_select)
        SEL_CMD: begin
          cmd_status_next = req_word.bus_data;
          byte_count_next = '0;
          active_next     = (req_word.bus_data != CMD_NONE);
        end
        SEL_PAGE_LO: page_low_next  = req_word.bus_data;
        SEL_PAGE_HI: page_high_next = req_word.bus_data;
        SEL_SLOT:    slot_reg_next  = req_word.bus_data;
        SEL_BUS:     muted_next     = (req_word.bus_data == MuteCode);
        default: ;
      endcase
    end else if (active) begin
      if (cmd_status == CMD_NONE) begin
        active_next = 1'b0;
      end else if (cmd_status == CMD_GETSIZE) begin
        page_low_next   = MAX_PAGE_BYTE;
        page_high_next  = MAX_PAGE_BYTE;
        slot_reg_next   = MAX_SLOT;
        cmd_status_next = cmd_status | STAT_DONE;
        finish          = 1'b1;
      end else if (cmd_status == CMD_SYNC) begin
        cmd_status_next   = cmd_status | STAT_DONE;
        sync_pending_next = 1'b1;
        active_next       = 1'b0;
      end else begin
        if (slot_reg == 8'd0 || slot_reg > MAX_SLOT) begin
          cmd_status_next = STAT_ERR_SLOT;
          finish          = 1'b1;
          failed          = 1'b1;
        end else if (!seeked) begin
          rsp_word.seek_valid   = 1'b1;
          rsp_word.seek_address = seek_addr_calc;
          if (!req_word.seek_ok) begin
            cmd_status_next = STAT_ERR_SEEK;
            finish          = 1'b1;
            failed          = 1'b1;
          end else begin
            seeked_next = 1'b1;
          end
        end
        if (!failed) begin
          rsp_word.mem_slot   = slot_reg[3:0];
          rsp_word.mem_offset = byte_count[11:0] & off_mask;
          byte_count_next     = count_inc;
          rsp_word.xfer_write = wr;
          if (wr) begin
            rsp_word.disk_write_data = req_word.mem_byte;
            if (!req_word.io_ok) begin
              cmd_status_next = STAT_ERR_WRITE;
              finish          = 1'b1;
              failed          = 1'b1;
            end
          end else if (!req_word.io_ok) begin
            cmd_status_next = STAT_ERR_READ;
            finish          = 1'b1;
            failed          = 1'b1;
          end else begin
            rsp_word.mem_write_data = req_word.read_eof ? 8'd0 : req_word.disk_byte;
          end
          if (!failed) begin
            rsp_word.xfer_valid = 1'b1;
            // The count wraps at 16 bits, so a limit beyond that range never ends the run.
            if (CmpW'(count_inc) >= CmpW'(limit)) begin
              cmd_status_next = cmd_status | STAT_DONE;
              finish          = 1'b1;
              seeked_next     = 1'b0;
            end
          end
        end
      end

      if (finish) begin
        active_next = 1'b0;
        // A pending sync swallows exactly one interrupt.
        rsp_word.irq_raise = !sync_pending && !muted;
        sync_pending_next  = 1'b0;
      end
    end

    rsp_word.status     = cmd_status_next;
    rsp_word.param_word = {slot_reg_next, page_high_next, page_low_next};
    rsp_word.busy_res   = active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_status   <= '0;
      page_low     <= '0;
      page_high    <= '0;
      slot_reg     <= '0;
      byte_count   <= '0;
      active       <= 1'b0;
      seeked       <= 1'b0;
      sync_pending <= 1'b0;
      muted        <= 1'b0;
    end else if (fire) begin
      cmd_status   <= cmd_status_next;
      page_low     <= page_low_next;
      page_high    <= page_high_next;
      slot_reg     <= slot_reg_next;
      byte_count   <= byte_count_next;
      active       <= active_next;
      seeked       <= seeked_next;
      sync_pending <= sync_pending_next;
      muted        <= muted_next;
    end
  end

endmodule

// File: dv/paged_disk_dma_controller_tb.sv
// Self-checking testbench for the paged disk DMA controller.
module paged_disk_dma_controller_tb;
  import pddc_pkg::*;

  localparam int PageShift   = PageShiftDef;
  localparam int RunLimit    = 5_000_000;
  localparam int DrainCycles = 8;
  localparam int ItemTarget  = 1050;
  localparam int PrintCap    = 60;

  localparam logic [2:0] SelUnused = 3'd7;

  typedef struct {
    req_word_t word;
    bit        drain_first;
  } disk_op_t;

  logic clk;
  logic rst;

  pddc_req_if req_ch ();
  pddc_rsp_if rsp_ch ();

  paged_disk_dma_controller #(.PAGE_SHIFT(PageShift)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  // Predicted controller registers.
  logic [7:0]  ctl_status     = '0;
  logic [7:0]  ctl_page_lo    = '0;
  logic [7:0]  ctl_page_hi    = '0;
  logic [7:0]  ctl_slot       = '0;
  logic [15:0] ctl_moved      = '0;
  logic        ctl_running    = 1'b0;
  logic        ctl_positioned = 1'b0;
  logic        ctl_sync_held  = 1'b0;
  logic        ctl_muted      = 1'b0;

  disk_op_t  pending_ops[$];
  rsp_word_t awaited_rsp[$];
  req_word_t on_bus;
  bit        on_bus_live;
  bit        drain_next;
  bit        quiet_src;
  bit        quiet_snk;
  int        n_accepted;
  int        n_checked;
  int        n_errors;
  int        src_wait;
  int        snk_wait;
  int        cycle_cnt;
  int        stim_count;

  // ---------------------------------------------------------------- prediction

  function automatic bit interrupt_due();
    if (ctl_sync_held) begin
      ctl_sync_held = 1'b0;
      return 1'b0;
    end
    return !ctl_muted;
  endfunction

  function automatic bit end_with_done();
    ctl_status  = ctl_status | STAT_DONE;
    ctl_running = 1'b0;
    return interrupt_due();
  endfunction

  function automatic bit end_with_error(logic [7:0] code);
    ctl_status  = code;
    ctl_running = 1'b0;
    return interrupt_due();
  endfunction

  function automatic rsp_word_t advance_controller(req_word_t w);
    rsp_word_t  r;
    logic [3:0] width;
    logic       to_disk;
    logic       failed;
    r = '0;
    if (!w.command) begin
      case (w.reg_select)
        SEL_CMD: begin
          ctl_status  = w.bus_data;
          ctl_moved   = '0;
          ctl_running = (w.bus_data != CMD_NONE);
        end
        SEL_PAGE_LO: ctl_page_lo = w.bus_data;
        SEL_PAGE_HI: ctl_page_hi = w.bus_data;
        SEL_SLOT:    ctl_slot = w.bus_data;
        SEL_BUS:     ctl_muted = (w.bus_data == MuteCode);
        default: ;
      endcase
    end else if (ctl_running) begin
      if (ctl_status == CMD_NONE) begin
        ctl_running = 1'b0;
      end else if (ctl_status == CMD_GETSIZE) begin
        ctl_page_lo = MAX_PAGE_BYTE;
        ctl_page_hi = MAX_PAGE_BYTE;
        ctl_slot    = MAX_SLOT;
        r.irq_raise = end_with_done();
      end else if (ctl_status == CMD_SYNC) begin
        ctl_status    = ctl_status | STAT_DONE;
        ctl_sync_held = 1'b1;
        ctl_running   = 1'b0;
      end else begin
        width   = ctl_status[3:0];
        to_disk = ctl_status[CmdWriteBit];
        failed  = 1'b0;
        if (ctl_slot == 8'h00 || ctl_slot > MAX_SLOT) begin
          r.irq_raise = end_with_error(STAT_ERR_SLOT);
          failed = 1'b1;
        end else if (!ctl_positioned) begin
          r.seek_valid   = 1'b1;
          r.seek_address = 28'(int'({ctl_page_hi, ctl_page_lo}) << PageShift);
          if (!w.seek_ok) begin
            r.irq_raise = end_with_error(STAT_ERR_SEEK);
            failed = 1'b1;
          end else begin
            ctl_positioned = 1'b1;
          end
        end
        if (!failed) begin
          r.mem_slot   = ctl_slot[3:0];
          r.mem_offset = 12'(int'(ctl_moved) & ((1 << PageShift) - 1));
          ctl_moved    = ctl_moved + 16'd1;
          r.xfer_write = to_disk;
          if (to_disk) begin
            r.disk_write_data = w.mem_byte;
            if (!w.io_ok) begin
              r.irq_raise = end_with_error(STAT_ERR_WRITE);
              failed = 1'b1;
            end
          end else if (!w.io_ok) begin
            r.irq_raise = end_with_error(STAT_ERR_READ);
            failed = 1'b1;
          end else begin
            r.mem_write_data = w.read_eof ? 8'h00 : w.disk_byte;
          end
          if (!failed) begin
            r.xfer_valid = 1'b1;
            // The counter is 16 bits wide, so a limit above 65535 is never met.
            if (int'(ctl_moved) >= (int'(width) << PageShift)) begin
              r.irq_raise    = end_with_done();
              ctl_positioned = 1'b0;
            end
          end else begin
            r.mem_write_data = 8'h00;
          end
        end
      end
    end
    r.status     = ctl_status;
    r.param_word = {ctl_slot, ctl_page_hi, ctl_page_lo};
    r.busy_res   = ctl_running;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic bit chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [7:0] xfer_cmd(bit wr, logic [3:0] width, logic [2:0] upper);
    return {upper, wr, width};
  endfunction

  // Unused fields carry random values so that every input bit moves.
  function automatic disk_op_t bus_op(logic [2:0] sel, logic [7:0] data);
    disk_op_t op;
    op.word            = req_word_t'(31'($urandom));
    op.word.command    = 1'b0;
    op.word.reg_select = sel;
    op.word.bus_data   = data;
    op.drain_first     = 1'b0;
    return op;
  endfunction

  function automatic disk_op_t tick_op(bit seek_ok, bit io_ok, bit eof);
    disk_op_t op;
    op.word          = req_word_t'(31'($urandom));
    op.word.command  = 1'b1;
    op.word.seek_ok  = seek_ok;
    op.word.io_ok    = io_ok;
    op.word.read_eof = eof;
    op.drain_first   = 1'b0;
    return op;
  endfunction

  function automatic disk_op_t rand_tick();
    return tick_op(chance(90), chance(85), chance(25));
  endfunction

  function automatic logic [7:0] rand_slot();
    if (chance(85)) return 8'($urandom_range(1, 15));
    return chance(50) ? 8'h00 : 8'($urandom_range(16, 255));
  endfunction

  task automatic push_op(disk_op_t op);
    op.drain_first = op.drain_first | drain_next;
    drain_next = 1'b0;
    pending_ops.push_back(op);
    stim_count++;
  endtask

  task automatic add_session();
    int         n;
    int         kind;
    logic [7:0] cmd;
    kind = $urandom_range(0, 99);
    if (chance(3)) drain_next = 1'b1;
    if (kind < 10) begin
      // Stray writes, unused selects included, and ticks that may find the
      // controller idle; they are not counted as stimulus.
      n = $urandom_range(1, 3);
      repeat (n) begin
        if (chance(50)) pending_ops.push_back(bus_op(3'($urandom_range(0, 7)), 8'($urandom)));
        else pending_ops.push_back(tick_op(chance(50), chance(50), chance(50)));
      end
    end else if (kind < 17) begin
      if (chance(50)) push_op(bus_op(SEL_BUS, chance(50) ? MuteCode : 8'($urandom)));
      push_op(bus_op(SEL_CMD, CMD_GETSIZE));
      push_op(rand_tick());
    end else if (kind < 24) begin
      push_op(bus_op(SEL_CMD, CMD_SYNC));
      push_op(rand_tick());
      push_op(bus_op(SEL_CMD, xfer_cmd(chance(50), 4'd0, 3'($urandom))));
      push_op(rand_tick());
    end else begin
      if (chance(50)) begin
        push_op(bus_op(SEL_PAGE_LO, 8'($urandom)));
        push_op(bus_op(SEL_PAGE_HI, 8'($urandom)));
      end
      if (chance(70)) push_op(bus_op(SEL_SLOT, rand_slot()));
      if (chance(15)) push_op(bus_op(SEL_BUS, chance(50) ? MuteCode : 8'($urandom)));
      if (kind < 34) begin
        // Wide transfer cut short by the next command write; the seek state
        // carries over into it.
        cmd = xfer_cmd(chance(50), 4'($urandom_range(1, 15)), 3'($urandom));
        n   = $urandom_range(1, 6);
      end else begin
        cmd = xfer_cmd(chance(50), 4'd0, 3'($urandom));
        n   = $urandom_range(1, 3);
      end
      push_op(bus_op(SEL_CMD, cmd));
      repeat (n) push_op(rand_tick());
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what);
    // Later mismatches are only counted.
    if (n_errors < PrintCap) $display("MISMATCH: %s", what);
    n_errors++;
  endtask

  task automatic check_field(string fname, int idx, logic [27:0] got, logic [27:0] want);
    if (got !== want)
      report_mismatch($sformatf("word %0d: %s is %h, expected %h", idx, fname, got, want));
  endtask

  task automatic check_response(rsp_word_t got, rsp_word_t want, int idx);
    check_field("status", idx, 28'(got.status), 28'(want.status));
    check_field("param_word", idx, 28'(got.param_word), 28'(want.param_word));
    check_field("irq_raise", idx, 28'(got.irq_raise), 28'(want.irq_raise));
    check_field("busy_res", idx, 28'(got.busy_res), 28'(want.busy_res));
    check_field("seek_valid", idx, 28'(got.seek_valid), 28'(want.seek_valid));
    check_field("seek_address", idx, got.seek_address, want.seek_address);
    check_field("xfer_valid", idx, 28'(got.xfer_valid), 28'(want.xfer_valid));
    check_field("xfer_write", idx, 28'(got.xfer_write), 28'(want.xfer_write));
    check_field("mem_slot", idx, 28'(got.mem_slot), 28'(want.mem_slot));
    check_field("mem_offset", idx, 28'(got.mem_offset), 28'(want.mem_offset));
    check_field("mem_write_data", idx, 28'(got.mem_write_data), 28'(want.mem_write_data));
    check_field("disk_write_data", idx, 28'(got.disk_write_data), 28'(want.disk_write_data));
  endtask

  // ---------------------------------------------------------------- clock and run

  initial begin
    clk                = 1'b0;
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.command     = 1'b0;
    req_ch.reg_select  = '0;
    req_ch.bus_data    = '0;
    req_ch.seek_ok     = 1'b0;
    req_ch.io_ok       = 1'b0;
    req_ch.read_eof    = 1'b0;
    req_ch.disk_byte   = '0;
    req_ch.mem_byte    = '0;
    rsp_ch.ready       = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if ($urandom_range(0, 399) == 0) quiet_src <= !quiet_src;
    if ($urandom_range(0, 399) == 0) quiet_snk <= !quiet_snk;
    if (cycle_cnt > RunLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Driver: presents the next pending word once the previous one is taken.
  always @(posedge clk) begin
    disk_op_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
      on_bus_live = 1'b0;
      src_wait    = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        awaited_rsp.push_back(advance_controller(on_bus));
        n_accepted++;
        on_bus_live = 1'b0;
        src_wait    = pick_gap(quiet_src);
      end
      if (!on_bus_live && src_wait > 0) begin
        src_wait--;
      end else if (!on_bus_live && pending_ops.size() != 0 &&
                   (!pending_ops[0].drain_first || n_checked == n_accepted)) begin
        nxt = pending_ops.pop_front();
        on_bus      = nxt.word;
        on_bus_live = 1'b1;
      end
      req_ch.valid      <= on_bus_live;
      req_ch.command    <= on_bus.command;
      req_ch.reg_select <= on_bus.reg_select;
      req_ch.bus_data   <= on_bus.bus_data;
      req_ch.seek_ok    <= on_bus.seek_ok;
      req_ch.io_ok      <= on_bus.io_ok;
      req_ch.read_eof   <= on_bus.read_eof;
      req_ch.disk_byte  <= on_bus.disk_byte;
      req_ch.mem_byte   <= on_bus.mem_byte;
    end
  end

  // Monitor: checks each response word against the oldest prediction.
  always @(posedge clk) begin
    rsp_word_t got;
    rsp_word_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      snk_wait = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status          = rsp_ch.status;
        got.param_word      = rsp_ch.param_word;
        got.irq_raise       = rsp_ch.irq_raise;
        got.busy_res        = rsp_ch.busy_res;
        got.seek_valid      = rsp_ch.seek_valid;
        got.seek_address    = rsp_ch.seek_address;
        got.xfer_valid      = rsp_ch.xfer_valid;
        got.xfer_write      = rsp_ch.xfer_write;
        got.mem_slot        = rsp_ch.mem_slot;
        got.mem_offset      = rsp_ch.mem_offset;
        got.mem_write_data  = rsp_ch.mem_write_data;
        got.disk_write_data = rsp_ch.disk_write_data;
        if (awaited_rsp.size() == 0) begin
          report_mismatch($sformatf("response word with none outstanding, status %h",
                                    got.status));
        end else begin
          want = awaited_rsp.pop_front();
          check_response(got, want, n_checked);
          n_checked <= n_checked + 1;
        end
        snk_wait = pick_gap(quiet_snk);
      end
      if (snk_wait > 0) begin
        snk_wait--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    disk_op_t op;

    // Directed opening: idle tick, unused select, every error, both special
    // commands, muting, sync swallowing an interrupt and extreme values.
    push_op(tick_op(1'b1, 1'b1, 1'b0));
    push_op(bus_op(SelUnused, 8'hFF));
    push_op(bus_op(SEL_CMD, xfer_cmd(1'b0, 4'd1, 3'd0)));
    push_op(tick_op(1'b1, 1'b1, 1'b0));
    push_op(bus_op(SEL_BUS, MuteCode));
    push_op(bus_op(SEL_CMD, CMD_GETSIZE));
    push_op(tick_op(1'b1, 1'b1, 1'b0));
    push_op(bus_op(SEL_BUS, 8'hFF));
    push_op(bus_op(SEL_CMD, xfer_cmd(1'b0, 4'd0, 3'b100)));
    op = tick_op(1'b1, 1'b1, 1'b0);
    op.word.disk_byte = 8'hFF;
    push_op(op);
    push_op(bus_op(SEL_CMD, xfer_cmd(1'b1, 4'd0, 3'b000)));
    op = tick_op(1'b1, 1'b0, 1'b0);
    op.word.mem_byte = 8'hFF;
    push_op(op);
    push_op(bus_op(SEL_CMD, CMD_SYNC));
    push_op(tick_op(1'b0, 1'b0, 1'b0));
    // The failed write left the seek in place, so this read issues none.
    push_op(bus_op(SEL_CMD, xfer_cmd(1'b0, 4'd0, 3'b010)));
    push_op(tick_op(1'b0, 1'b1, 1'b1));
    push_op(bus_op(SEL_PAGE_LO, 8'h00));
    push_op(bus_op(SEL_PAGE_HI, 8'h00));
    push_op(bus_op(SEL_CMD, xfer_cmd(1'b1, 4'd15, 3'b010)));
    push_op(tick_op(1'b0, 1'b1, 1'b0));
    push_op(bus_op(SEL_CMD, xfer_cmd(1'b0, 4'd0, 3'b110)));
    push_op(tick_op(1'b1, 1'b0, 1'b0));
    push_op(bus_op(SEL_SLOT, 8'hFF));
    push_op(bus_op(SEL_CMD, xfer_cmd(1'b1, 4'd0, 3'b000)));
    push_op(tick_op(1'b1, 1'b1, 1'b0));

    stim_count = 0;
    drain_next = 1'b1;
    while (stim_count < ItemTarget) begin
      add_session();
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || on_bus_live || n_checked != n_accepted)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (awaited_rsp.size() != 0)
      report_mismatch($sformatf("%0d response words never arrived", awaited_rsp.size()));
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/pddc_pkg.sv
rtl/pddc_req_if.sv
rtl/pddc_rsp_if.sv
rtl/pddc_exec.sv
rtl/paged_disk_dma_controller.sv
dv/paged_disk_dma_controller_tb.sv
